@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Depends on nothing; take it in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/hfwg_pkg.sv @@
// Package of the height field wave grid: types, codes, constants, helpers.
// Depends on nothing.
`default_nettype none

package hfwg_pkg;

   localparam int DEFAULT_GRID_DIM = 64;
   localparam int DATA_W = 32;
   localparam int DIV_W = 9;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] OP_POKE = 2'd0;
   localparam logic [1:0] OP_STEP = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd1;

   localparam logic signed [31:0] POKE_LEVEL = 32'sh0008_0000;
   localparam logic signed [16:0] INV_SQRT2_Q16 = 17'sd46341;
   localparam logic signed [11:0] RATE_Q16 = 12'sd1311;

   typedef struct packed {
      logic [1:0] op;
      logic [5:0] x_start;
      logic [6:0] x_end;
      logic [5:0] y_start;
      logic [6:0] y_end;
      logic       poke_up;
   } req_type;

   typedef struct packed {
      logic signed [31:0] height_out;
      logic signed [31:0] velocity_out;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [31:0]      dividend;
      logic [DIV_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
      logic signed [1:0] d;
      case (k)
         3'd1, 3'd5, 3'd7: d = -2'sd1;
         3'd3, 3'd4, 3'd6: d = 2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
      logic signed [1:0] d;
      case (k)
         3'd0, 3'd5, 3'd6: d = -2'sd1;
         3'd2, 3'd4, 3'd7: d = 2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic logic nb_diag(input logic [2:0] k);
      return k[2];
   endfunction

   function automatic logic out32(input logic signed [47:0] v);
      return v[47:31] != {17{v[31]}};
   endfunction

   function automatic logic signed [31:0] clip32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (out32(v)) begin
         r = v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/hfwg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module hfwg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/hfwg_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on hfwg_pkg.
`default_nettype none

module hfwg_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hfwg_pkg::div_cmd_type cmd,
   output hfwg_pkg::div_rsp_type     rsp
);

   localparam int CNT_W = $clog2(33);

   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       done_ff, done_in;
   logic [31:0]                dvd_ff, dvd_in;
   logic [hfwg_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [hfwg_pkg::DIV_W-1:0] dvs_ff, dvs_in;
   logic [hfwg_pkg::DIV_W:0]   shifted;

   always_comb begin
      cnt_in = cnt_ff;
      done_in = 1'b0;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      shifted = {rem_ff, dvd_ff[31]};
      if (cmd.start) begin
         cnt_in = CNT_W'(32);
         dvd_in = cmd.dividend;
         rem_in = '0;
         dvs_in = cmd.divisor;
      end else if (cnt_ff != '0) begin
         // Shift in one dividend bit, subtract where it fits.
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = hfwg_pkg::DIV_W'(shifted - {1'b0, dvs_ff});
            dvd_in = {dvd_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[hfwg_pkg::DIV_W-1:0];
            dvd_in = {dvd_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = dvd_ff;

endmodule

`default_nettype wire

@@ src/height_field_wave_grid_top.sv @@
// Top level of the height field wave grid: sequencer, datapath, grid memories.
// Depends on hfwg_pkg, hfwg_ram, hfwg_div and assert_macros.svh.
//
// Usage:
//   Requests enter on req_payload when start is high and busy is low. Each
//   request yields exactly one result, shown on rsp_payload for one cycle
//   with rsp_valid high; the receiver cannot stall, so take it then.
//   Op poke fills a rectangle of heights with +8 or -8, op step runs one
//   relaxation update of the grid in use, op read returns one node.
//   Grid size is set through the csr_ channel (index 0 columns, 1 rows),
//   always ready; write it only while the block is idle.
// Sequence:
//   After reset the height and velocity memories are cleared one node per
//   cycle; busy stays high.
//   Read addresses the node, then takes its height and velocity. Poke
//   writes its cells row by row. Op 3 or an empty poke goes straight to the
//   result. Step runs a force pass (one height read per neighbour through
//   the single read port), then an update pass per node that waits on the
//   bit-serial divider.
`default_nettype none
`include "assert_macros.svh"

module height_field_wave_grid_top #(
   parameter int GRID_DIM = hfwg_pkg::DEFAULT_GRID_DIM
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire hfwg_pkg::req_type               req_payload,
   output logic                                 rsp_valid,
   output hfwg_pkg::rsp_type                    rsp_payload,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [hfwg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [6:0]                      csr_data
);

   localparam int CELLS = GRID_DIM * GRID_DIM;
   localparam int AW = $clog2(CELLS);
   localparam int CW = $clog2(GRID_DIM);
   localparam int DW = $clog2(GRID_DIM + 1);
   localparam int WW = ((DW > 7) ? DW : 7) + 1;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_POKE    = 4'd2;
   localparam logic [3:0] S_READ0   = 4'd3;
   localparam logic [3:0] S_READ1   = 4'd4;
   localparam logic [3:0] S_FORCE   = 4'd5;
   localparam logic [3:0] S_UPD_RD  = 4'd6;
   localparam logic [3:0] S_UPD_MUL = 4'd7;
   localparam logic [3:0] S_UPD_ADD = 4'd8;
   localparam logic [3:0] S_UPD_H   = 4'd9;
   localparam logic [3:0] S_UPD_DS  = 4'd10;
   localparam logic [3:0] S_UPD_DIV = 4'd11;
   localparam logic [3:0] S_UPD_WR  = 4'd12;
   localparam logic [3:0] S_DONE    = 4'd13;

   localparam logic [3:0] SLOT_LAST_ISSUE = 4'd8;
   localparam logic [3:0] SLOT_WRITE      = 4'd11;

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx,
                                                input logic [CW-1:0] cy);
      return AW'(AW'(cy) * AW'(GRID_DIM)) + AW'(cx);
   endfunction

   function automatic logic [DW-1:0] clamp_dim(input logic [6:0] v);
      logic [WW-1:0] w;
      logic [DW-1:0] r;
      w = WW'(v);
      if (w < WW'(2)) begin
         r = DW'(2);
      end else if (w > WW'(GRID_DIM)) begin
         r = DW'(GRID_DIM);
      end else begin
         r = DW'(w);
      end
      return r;
   endfunction

   function automatic logic [31:0] clip32_acc(input logic signed [39:0] a);
      return hfwg_pkg::clip32(48'(a));
   endfunction

   // Control state
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [DW-1:0] cols_ff, cols_in;
   logic [DW-1:0] rows_ff, rows_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          t1_valid_ff, t1_valid_in;
   logic          t2_valid_ff, t2_valid_in;

   // Walk and datapath registers
   logic [CW-1:0]      x_ff, x_in, y_ff, y_in, xs_ff, xs_in;
   logic [WW-1:0]      xe_ff, xe_in, ye_ff, ye_in;
   logic [3:0]         slot_ff, slot_in;
   logic               up_ff, up_in;
   logic signed [31:0] hc_ff, hc_in;
   logic               t1_centre_ff, t1_centre_in, t1_diag_ff, t1_diag_in;
   logic               t2_diag_ff, t2_diag_in;
   logic signed [32:0] e_ff, e_in;
   logic signed [49:0] prod_ff, prod_in;
   logic signed [39:0] acc_ff, acc_in;
   logic               sat_ff, sat_in;
   logic signed [31:0] hv_ff, hv_in, vv_ff, vv_in;
   logic signed [43:0] fprod_ff, fprod_in;
   logic signed [31:0] vn_ff, vn_in, h1_ff, h1_in;
   logic signed [31:0] res_h_ff, res_h_in, res_v_ff, res_v_in;
   hfwg_pkg::rsp_type  rsp_ff, rsp_in;

   // Memory ports
   logic          h_we, v_we, f_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   h_wdata, v_wdata, f_wdata;
   logic [31:0]   h_rdata, v_rdata, f_rdata;

   hfwg_pkg::div_cmd_type div_cmd;
   hfwg_pkg::div_rsp_type div_rsp;

   // Combinational helpers
   logic [WW-1:0]      cols_w, rows_w, xe_eff, ye_eff;
   logic [2:0]         nb_k;
   logic signed [1:0]  dx, dy;
   logic signed [WW:0] nx_w, ny_w;
   logic               nb_ok, last_x, last_y;
   logic signed [32:0] e_c;
   logic signed [49:0] rnd_p, rnd_n;
   logic signed [39:0] term;
   logic signed [43:0] rnd_f;
   logic signed [47:0] wide_sum;
   logic signed [31:0] h_new;

   assign cols_w = WW'(cols_ff);
   assign rows_w = WW'(rows_ff);
   assign last_x = (WW'(x_ff) + WW'(1)) == cols_w;
   assign last_y = (WW'(y_ff) + WW'(1)) == rows_w;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cols_in = cols_ff;
      rows_in = rows_ff;
      rsp_valid_in = 1'b0;
      t1_valid_in = 1'b0;
      t2_valid_in = 1'b0;
      x_in = x_ff;
      y_in = y_ff;
      xs_in = xs_ff;
      xe_in = xe_ff;
      ye_in = ye_ff;
      slot_in = slot_ff;
      up_in = up_ff;
      hc_in = hc_ff;
      t1_centre_in = t1_centre_ff;
      t1_diag_in = t1_diag_ff;
      t2_diag_in = t2_diag_ff;
      e_in = e_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      sat_in = sat_ff;
      hv_in = hv_ff;
      vv_in = vv_ff;
      fprod_in = fprod_ff;
      vn_in = vn_ff;
      h1_in = h1_ff;
      res_h_in = res_h_ff;
      res_v_in = res_v_ff;
      rsp_in = rsp_ff;

      h_we = 1'b0;
      v_we = 1'b0;
      f_we = 1'b0;
      wr_addr = cell_addr(x_ff, y_ff);
      rd_addr = cell_addr(x_ff, y_ff);
      h_wdata = '0;
      v_wdata = '0;
      f_wdata = clip32_acc(acc_ff);
      div_cmd.start = 1'b0;
      div_cmd.dividend = h1_ff[31] ? 32'(-h1_ff) : h1_ff;
      div_cmd.divisor = hfwg_pkg::DIV_W'(cols_ff) + hfwg_pkg::DIV_W'(rows_ff);

      xe_eff = (WW'(req_payload.x_end) < cols_w) ? WW'(req_payload.x_end) : cols_w;
      ye_eff = (WW'(req_payload.y_end) < rows_w) ? WW'(req_payload.y_end) : rows_w;

      // Neighbour geometry for the current force slot
      nb_k = 3'(slot_ff - 4'd1);
      dx = hfwg_pkg::nb_dx(nb_k);
      dy = hfwg_pkg::nb_dy(nb_k);
      nx_w = $signed({1'b0, WW'(x_ff)}) + $signed({{(WW - 1){dx[1]}}, dx});
      ny_w = $signed({1'b0, WW'(y_ff)}) + $signed({{(WW - 1){dy[1]}}, dy});
      nb_ok = !nx_w[WW] && !ny_w[WW] && (nx_w[WW-1:0] < cols_w)
              && (ny_w[WW-1:0] < rows_w);

      // Force pipeline arithmetic
      e_c = $signed({h_rdata[31], h_rdata}) - $signed({hc_ff[31], hc_ff});
      rnd_p = (prod_ff + 50'sd32768) >>> 16;
      rnd_n = (-prod_ff + 50'sd32768) >>> 16;
      term = t2_diag_ff ? 40'(rnd_p - rnd_n) : 40'($signed({e_ff, 1'b0}));

      // Update arithmetic
      rnd_f = (fprod_ff + 44'sd32768) >>> 16;
      wide_sum = '0;
      h_new = h1_ff[31] ? h1_ff + $signed(div_rsp.quotient)
                        : h1_ff - $signed(div_rsp.quotient);

      // Register writes are taken in any state
      if (csr_valid) begin
         case (csr_index)
            hfwg_pkg::CSR_COLUMNS: cols_in = clamp_dim(csr_data);
            hfwg_pkg::CSR_ROWS: rows_in = clamp_dim(csr_data);
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            // Zero heights and velocities, one node a cycle
            h_we = 1'b1;
            v_we = 1'b1;
            wr_addr = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               res_h_in = '0;
               res_v_in = '0;
               sat_in = 1'b0;
               case (req_payload.op)
                  hfwg_pkg::OP_POKE: begin
                     if (WW'(req_payload.x_start) >= xe_eff
                         || WW'(req_payload.y_start) >= ye_eff) begin
                        state_in = S_DONE;
                     end else begin
                        x_in = CW'(req_payload.x_start);
                        xs_in = CW'(req_payload.x_start);
                        y_in = CW'(req_payload.y_start);
                        xe_in = xe_eff;
                        ye_in = ye_eff;
                        up_in = req_payload.poke_up;
                        state_in = S_POKE;
                     end
                  end
                  hfwg_pkg::OP_STEP: begin
                     x_in = '0;
                     y_in = '0;
                     slot_in = '0;
                     acc_in = '0;
                     state_in = S_FORCE;
                  end
                  hfwg_pkg::OP_READ: begin
                     if (WW'(req_payload.x_start) < cols_w
                         && WW'(req_payload.y_start) < rows_w) begin
                        x_in = CW'(req_payload.x_start);
                        y_in = CW'(req_payload.y_start);
                        state_in = S_READ0;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_POKE: begin
            h_we = 1'b1;
            h_wdata = up_ff ? hfwg_pkg::POKE_LEVEL : -hfwg_pkg::POKE_LEVEL;
            if ((WW'(x_ff) + WW'(1)) == xe_ff) begin
               x_in = xs_ff;
               y_in = y_ff + CW'(1);
               if ((WW'(y_ff) + WW'(1)) == ye_ff) begin
                  state_in = S_DONE;
               end
            end else begin
               x_in = x_ff + CW'(1);
            end
         end
         S_READ0: state_in = S_READ1;
         S_READ1: begin
            res_h_in = h_rdata;
            res_v_in = v_rdata;
            state_in = S_DONE;
         end
         S_FORCE: begin
            // Slot 0 reads the centre, slots 1..8 the neighbours
            if (slot_ff <= SLOT_LAST_ISSUE) begin
               if (slot_ff != 4'd0) begin
                  rd_addr = cell_addr(nx_w[CW-1:0], ny_w[CW-1:0]);
               end
               t1_valid_in = (slot_ff == 4'd0) || nb_ok;
               t1_centre_in = (slot_ff == 4'd0);
               t1_diag_in = hfwg_pkg::nb_diag(nb_k);
            end
            if (t1_valid_ff && t1_centre_ff) begin
               hc_in = h_rdata;
            end
            if (t1_valid_ff && !t1_centre_ff) begin
               t2_valid_in = 1'b1;
               t2_diag_in = t1_diag_ff;
               e_in = e_c;
               prod_in = e_c * hfwg_pkg::INV_SQRT2_Q16;
            end
            if (t2_valid_ff) begin
               acc_in = acc_ff + term;
            end
            slot_in = slot_ff + 4'd1;
            if (slot_ff == SLOT_WRITE) begin
               // Store the clipped force, advance to the next centre
               f_we = 1'b1;
               if (hfwg_pkg::out32(48'(acc_ff))) begin
                  sat_in = 1'b1;
               end
               acc_in = '0;
               slot_in = '0;
               if (last_x) begin
                  x_in = '0;
                  y_in = y_ff + CW'(1);
                  if (last_y) begin
                     y_in = '0;
                     state_in = S_UPD_RD;
                  end
               end else begin
                  x_in = x_ff + CW'(1);
               end
            end
         end
         S_UPD_RD: state_in = S_UPD_MUL;
         S_UPD_MUL: begin
            hv_in = h_rdata;
            vv_in = v_rdata;
            fprod_in = $signed(f_rdata) * hfwg_pkg::RATE_Q16;
            state_in = S_UPD_ADD;
         end
         S_UPD_ADD: begin
            wide_sum = 48'(vv_ff) + 48'(rnd_f);
            vn_in = hfwg_pkg::clip32(wide_sum);
            if (hfwg_pkg::out32(wide_sum)) begin
               sat_in = 1'b1;
            end
            state_in = S_UPD_H;
         end
         S_UPD_H: begin
            wide_sum = 48'(hv_ff) + 48'(vn_ff);
            h1_in = hfwg_pkg::clip32(wide_sum);
            if (hfwg_pkg::out32(wide_sum)) begin
               sat_in = 1'b1;
            end
            state_in = S_UPD_DS;
         end
         S_UPD_DS: begin
            div_cmd.start = 1'b1;
            state_in = S_UPD_DIV;
         end
         S_UPD_DIV: begin
            if (div_rsp.done) begin
               state_in = S_UPD_WR;
            end
         end
         S_UPD_WR: begin
            // Damp the height and write back the node
            h_we = 1'b1;
            v_we = 1'b1;
            h_wdata = h_new;
            v_wdata = vn_ff;
            state_in = S_UPD_RD;
            if (last_x) begin
               x_in = '0;
               y_in = y_ff + CW'(1);
               if (last_y) begin
                  state_in = S_DONE;
               end
            end else begin
               x_in = x_ff + CW'(1);
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.height_out = res_h_ff;
            rsp_in.velocity_out = res_v_ff;
            rsp_in.saturated = sat_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         cols_ff <= DW'(GRID_DIM);
         rows_ff <= DW'(GRID_DIM);
         rsp_valid_ff <= 1'b0;
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
         t1_valid_ff <= t1_valid_in;
         t2_valid_ff <= t2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      xs_ff <= xs_in;
      xe_ff <= xe_in;
      ye_ff <= ye_in;
      slot_ff <= slot_in;
      up_ff <= up_in;
      hc_ff <= hc_in;
      t1_centre_ff <= t1_centre_in;
      t1_diag_ff <= t1_diag_in;
      t2_diag_ff <= t2_diag_in;
      e_ff <= e_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      sat_ff <= sat_in;
      hv_ff <= hv_in;
      vv_ff <= vv_in;
      fprod_ff <= fprod_in;
      vn_ff <= vn_in;
      h1_ff <= h1_in;
      res_h_ff <= res_h_in;
      res_v_ff <= res_v_in;
      rsp_ff <= rsp_in;
   end

   hfwg_ram #(.WIDTH(32), .DEPTH(CELLS)) u_height (
      .clock(clock), .wr_en(h_we), .wr_addr(wr_addr), .wr_data(h_wdata),
      .rd_addr(rd_addr), .rd_data(h_rdata)
   );

   hfwg_ram #(.WIDTH(32), .DEPTH(CELLS)) u_velocity (
      .clock(clock), .wr_en(v_we), .wr_addr(wr_addr), .wr_data(v_wdata),
      .rd_addr(rd_addr), .rd_data(v_rdata)
   );

   hfwg_ram #(.WIDTH(32), .DEPTH(CELLS)) u_force (
      .clock(clock), .wr_en(f_we), .wr_addr(wr_addr), .wr_data(f_wdata),
      .rd_addr(rd_addr), .rd_data(f_rdata)
   );

   hfwg_div u_div (
      .clock(clock), .reset(reset), .cmd(div_cmd), .rsp(div_rsp)
   );

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready = 1'b1;

   // An accepted request holds the block busy
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "request accepted but not busy")
   // One strobe per request: never two results back to back
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "result strobe too long")
   // A result comes out as the sequencer returns to idle
   `ASSERT_IMPLIES(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   // The divider only finishes while the update waits for it
   `ASSERT_IMPLIES(a_div_wait, clock, reset, div_rsp.done, state_ff == S_UPD_DIV, "stray divide")

endmodule

`default_nettype wire

@@ tb/tb_height_field_wave_grid_top.sv @@
// Self-checking testbench of height_field_wave_grid_top: pokes, steps and reads
// are predicted by a Q16.16 grid model in a small scoreboard class.
// Depends on hfwg_pkg and the block's RTL.
`default_nettype none

module tb_height_field_wave_grid_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hfwg_pkg::*;

   localparam int DIM = DEFAULT_GRID_DIM;
   localparam int CELL_COUNT = DIM * DIM;
   localparam int REQ_W = $bits(req_type);
   // Codes beyond the three operations and the two registers.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_payload;
   logic                 rsp_valid;
   rsp_type              rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [6:0]           csr_data;

   // Grid model plus the queue of results still owed by the block.
   class wave_scoreboard;
      int           error_count;
      int           cols;
      int           rows;
      int           height_q[CELL_COUNT];
      int           velocity_q[CELL_COUNT];
      rsp_type      expected_rsp[$];

      function new();
         error_count = 0;
         cols = DIM;
         rows = DIM;
         foreach (height_q[i]) begin
            height_q[i] = 0;
            velocity_q[i] = 0;
         end
      endfunction

      function int clamp_dim(input logic [6:0] v);
         if (v < 2) return 2;
         if (v > DIM) return DIM;
         return int'(v);
      endfunction

      function void set_register(input logic [CSR_IDX_W-1:0] idx, input logic [6:0] v);
         if (idx == CSR_COLUMNS) cols = clamp_dim(v);
         else if (idx == CSR_ROWS) rows = clamp_dim(v);
      endfunction

      // Round to nearest, ties upward: floor(v / 65536 + 0.5).
      function longint round16(input longint v);
         return (v + 64'sd32768) >>> 16;
      endfunction

      function int saturate32(input longint v, inout bit sat);
         if (v > 64'sd2147483647) begin
            sat = 1;
            return 32'sh7FFF_FFFF;
         end
         if (v < -64'sd2147483648) begin
            sat = 1;
            return 32'sh8000_0000;
         end
         return int'(v);
      endfunction

      function longint spring(input longint e, input bit diag);
         return diag ? round16(e * 46341) : e;
      endfunction

      // One relaxation update over the grid in use; returns the clip flag.
      function bit relax_grid();
         int     dx[8] = '{0, -1, 0, 1, 1, -1, 1, -1};
         int     dy[8] = '{-1, 0, 1, 0, 1, -1, -1, 1};
         int     force_q[CELL_COUNT];
         bit     sat;
         longint hc, hn, f, v, h1;
         int     nx, ny, idx, vn;
         sat = 0;
         for (int y = 0; y < rows; y++) begin
            for (int x = 0; x < cols; x++) begin
               hc = height_q[y * DIM + x];
               f = 0;
               for (int k = 0; k < 8; k++) begin
                  nx = x + dx[k];
                  ny = y + dy[k];
                  if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
                  hn = height_q[ny * DIM + nx];
                  f += spring(hn - hc, k >= 4) - spring(hc - hn, k >= 4);
               end
               force_q[y * DIM + x] = saturate32(f, sat);
            end
         end
         for (int y = 0; y < rows; y++) begin
            for (int x = 0; x < cols; x++) begin
               idx = y * DIM + x;
               v = longint'(velocity_q[idx]) + round16(longint'(force_q[idx]) * 1311);
               vn = saturate32(v, sat);
               h1 = saturate32(longint'(height_q[idx]) + vn, sat);
               velocity_q[idx] = vn;
               height_q[idx] = int'(h1 - h1 / longint'(cols + rows));
            end
         end
         return sat;
      endfunction

      function void note_request(input req_type r);
         rsp_type e;
         int      xe, ye;
         e = '0;
         case (r.op)
            OP_POKE: begin
               xe = (r.x_end > cols) ? cols : int'(r.x_end);
               ye = (r.y_end > rows) ? rows : int'(r.y_end);
               for (int y = r.y_start; y < ye; y++)
                  for (int x = r.x_start; x < xe; x++)
                     height_q[y * DIM + x] = r.poke_up ? POKE_LEVEL : -POKE_LEVEL;
            end
            OP_STEP: e.saturated = relax_grid();
            OP_READ: begin
               if (r.x_start < cols && r.y_start < rows) begin
                  e.height_out = height_q[r.y_start * DIM + r.x_start];
                  e.velocity_out = velocity_q[r.y_start * DIM + r.x_start];
               end
            end
            default: ;
         endcase
         expected_rsp.push_back(e);
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
         error_count++;
      endtask

      task check_result(input rsp_type r);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            report("unexpected result", r.height_out, 32'd0);
            return;
         end
         e = expected_rsp.pop_front();
         if (r.height_out !== e.height_out) report("height_out", r.height_out, e.height_out);
         if (r.velocity_out !== e.velocity_out)
            report("velocity_out", r.velocity_out, e.velocity_out);
         if (r.saturated !== e.saturated)
            report("saturated", 32'(r.saturated), 32'(e.saturated));
      endtask
   endclass

   wave_scoreboard sb = new();
   int idle_pct;

   height_field_wave_grid_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Take each result in the one cycle it is shown.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_payload);
   end

   // Hold the request until the block takes it, then idle for a random gap.
   task send_request(input req_type r);
      int gap;
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task make_request(input logic [1:0] op, input int xs, input int xe, input int ys,
                     input int ye, input bit up);
      req_type r;
      r.op = op;
      r.x_start = xs[5:0];
      r.x_end = xe[6:0];
      r.y_start = ys[5:0];
      r.y_end = ye[6:0];
      r.poke_up = up;
      send_request(r);
   endtask

   // Drop start and wait until every result owed has come back.
   task drain;
      start <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [6:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, v);
      csr_valid <= 1'b0;
   endtask

   task set_grid(input logic [6:0] c, input logic [6:0] r);
      drain();
      write_csr(CSR_COLUMNS, c);
      write_csr(CSR_ROWS, r);
   endtask

   // Mostly well-formed pokes and in-grid reads, some wild fields.
   task random_request;
      req_type r;
      int      pick;
      r = req_type'(REQ_W'({$urandom, $urandom}));
      pick = $urandom_range(99);
      if (pick < 35) begin
         r.op = OP_POKE;
         if ($urandom_range(3) != 0) begin
            r.x_start = 6'($urandom_range(sb.cols - 1));
            r.y_start = 6'($urandom_range(sb.rows - 1));
            r.x_end = 7'(r.x_start + $urandom_range(0, 4));
            r.y_end = 7'(r.y_start + $urandom_range(0, 4));
         end
      end else if (pick < 57) begin
         r.op = OP_STEP;
      end else if (pick < 95) begin
         r.op = OP_READ;
         if ($urandom_range(4) != 0) begin
            r.x_start = 6'($urandom_range(sb.cols - 1));
            r.y_start = 6'($urandom_range(sb.rows - 1));
         end
      end else begin
         r.op = OP_UNUSED;
      end
      send_request(r);
   endtask

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_pct = 16;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: full 64 x 64 grid, corners, one large step.
      make_request(OP_READ, 0, 0, 0, 0, 0);
      make_request(OP_READ, 63, 0, 63, 0, 1);
      make_request(OP_POKE, 0, 127, 0, 127, 1);
      make_request(OP_READ, 63, 0, 63, 0, 0);
      make_request(OP_POKE, 62, 64, 0, 1, 0);
      make_request(OP_STEP, 0, 0, 0, 0, 0);
      make_request(OP_READ, 0, 0, 0, 0, 0);
      make_request(OP_READ, 63, 0, 0, 0, 0);
      make_request(OP_READ, 32, 0, 32, 0, 0);

      // Below-range sizes clamp to 2 x 2; spare indexes must be ignored.
      set_grid(7'd0, 7'd1);
      write_csr(CSR_SPARE_A, 7'd5);
      write_csr(CSR_SPARE_B, 7'd127);
      make_request(OP_POKE, 0, 1, 0, 1, 1);
      make_request(OP_POKE, 1, 0, 1, 0, 0);
      make_request(OP_POKE, 1, 1, 0, 2, 0);
      make_request(OP_STEP, 0, 0, 0, 0, 0);
      make_request(OP_READ, 0, 0, 0, 0, 0);
      make_request(OP_READ, 1, 0, 1, 0, 0);
      make_request(OP_READ, 2, 0, 0, 0, 0);
      make_request(OP_READ, 63, 0, 63, 0, 0);
      make_request(OP_UNUSED, 63, 127, 63, 127, 1);
      make_request(OP_POKE, 1, 127, 0, 127, 0);
      make_request(OP_STEP, 0, 0, 0, 0, 0);
      make_request(OP_STEP, 0, 0, 0, 0, 0);
      make_request(OP_READ, 1, 0, 0, 0, 0);
      make_request(OP_READ, 0, 0, 1, 0, 0);

      // Random phases; sizes include above-range and skinny extremes.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_grid(7'd127, 7'd2);
            1: set_grid(7'd2, 7'd100);
            default: set_grid(7'($urandom_range(2, 10)), 7'($urandom_range(2, 10)));
         endcase
         idle_pct = (phase < 2) ? 16 : (phase < 4) ? 60 : 0;
         repeat (14) random_request();
      end

      drain();
      if (sb.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+src
src/hfwg_pkg.sv
src/hfwg_ram.sv
src/hfwg_div.sv
src/height_field_wave_grid_top.sv
tb/tb_height_field_wave_grid_top.sv
